[rtl/pse_pkg.sv]
// ----------------------------------------------------------------------------
// pse_pkg
// Shared types, constants and symbol decoding for the postfix stack evaluator.
// ----------------------------------------------------------------------------
package pse_pkg;

  localparam int unsigned STACK_DEPTH = 128;
  localparam int unsigned PTR_W       = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned SYM_W       = 8;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [SYM_W-1:0]  sym_t;

  localparam sym_t SYM_END   = 8'h00;
  localparam sym_t SYM_ZERO  = 8'h30;
  localparam sym_t SYM_NINE  = 8'h39;
  localparam sym_t SYM_PLUS  = 8'h2B;
  localparam sym_t SYM_MINUS = 8'h2D;
  localparam sym_t SYM_TIMES = 8'h2A;
  localparam sym_t SYM_SLASH = 8'h2F;
  localparam sym_t SYM_CARET = 8'h5E;

  typedef enum logic [2:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV,
    ALU_POW
  } alu_op_e;

  typedef enum logic [1:0] {
    ALU_IDLE,
    ALU_DIVIDE,
    ALU_POWER
  } alu_state_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RHS,
    S_LHS,
    S_WAIT,
    S_TERM
  } ctrl_state_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic div0;
  } alu_rsp_t;

  typedef struct packed {
    logic    is_end;
    logic    is_digit;
    logic    is_op;
    alu_op_e op;
  } sym_dec_t;

  function automatic sym_dec_t decode_sym(sym_t sym);
    sym_dec_t dec;
    dec.is_end   = (sym == SYM_END);
    dec.is_digit = (sym inside {[SYM_ZERO:SYM_NINE]});
    dec.is_op    = 1'b1;
    dec.op       = ALU_ADD;
    case (sym)
      SYM_PLUS:  dec.op = ALU_ADD;
      SYM_MINUS: dec.op = ALU_SUB;
      SYM_TIMES: dec.op = ALU_MUL;
      SYM_SLASH: dec.op = ALU_DIV;
      SYM_CARET: dec.op = ALU_POW;
      default:   dec.is_op = 1'b0;
    endcase
    return dec;
  endfunction

endpackage

[rtl/pse_if.sv]
// ----------------------------------------------------------------------------
// pse_if
// Valid/ready channels for expression symbols and for evaluation results.
// ----------------------------------------------------------------------------
interface pse_sym_if;
  logic          valid;
  logic          ready;
  pse_pkg::sym_t symbol;

  modport source (output valid, output symbol, input ready);
  modport sink   (input valid, input symbol, output ready);
endinterface

interface pse_res_if;
  logic                         valid;
  logic                         ready;
  logic signed [pse_pkg::WORD_W-1:0] value;
  logic                         underflow_seen;
  logic                         overflow_seen;
  logic                         divide_by_zero_seen;

  modport source (output valid, output value, output underflow_seen,
                  output overflow_seen, output divide_by_zero_seen, input ready);
  modport sink   (input valid, input value, input underflow_seen,
                  input overflow_seen, input divide_by_zero_seen, output ready);
endinterface

[rtl/pse_stack_mem.sv]
// ----------------------------------------------------------------------------
// pse_stack_mem
// Operand stack storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pse_stack_mem (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [pse_pkg::PTR_W-1:0] waddr_i,
  input  pse_pkg::word_t            wdata_i,
  input  logic                      re_i,
  input  logic [pse_pkg::PTR_W-1:0] raddr_i,
  output pse_pkg::word_t            rdata_o
);

  pse_pkg::word_t mem [pse_pkg::STACK_DEPTH];
  pse_pkg::word_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/pse_alu.sv]
// ----------------------------------------------------------------------------
// pse_alu
// Multi-cycle arithmetic unit: add, subtract and multiply,
// restoring signed division one quotient bit a cycle, and power by
// square-and-multiply one exponent bit a cycle.
// ----------------------------------------------------------------------------
module pse_alu (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pse_pkg::alu_req_t req_i,
  input  pse_pkg::word_t    a_i,
  input  pse_pkg::word_t    b_i,
  output pse_pkg::alu_rsp_t rsp_o,
  output pse_pkg::word_t    result_o
);

  localparam int unsigned STEP_W = $clog2(pse_pkg::WORD_W);

  pse_pkg::alu_state_e state_q, state_d;
  logic                done_q, done_d;
  logic                div0_q;
  pse_pkg::word_t      result_q;

  // Division registers.
  pse_pkg::word_t      quo_q, rem_q, mb_q;
  logic                neg_q;
  logic [STEP_W-1:0]   step_q;
  // Power registers.
  pse_pkg::word_t      acc_q, base_q, ex_q;

  logic                b_zero, pow_trivial;
  pse_pkg::word_t      ma, mb;
  logic [pse_pkg::WORD_W:0] rem_sh, diff;
  logic                ge;
  pse_pkg::word_t      rem_n, quo_n, acc_n;
  logic                div_last, pow_last;

  assign b_zero      = (b_i == '0);
  assign pow_trivial = b_i[pse_pkg::WORD_W-1] || b_zero;
  assign ma          = a_i[pse_pkg::WORD_W-1] ? (pse_pkg::word_t'(0) - a_i) : a_i;
  assign mb          = b_i[pse_pkg::WORD_W-1] ? (pse_pkg::word_t'(0) - b_i) : b_i;

  assign rem_sh = {rem_q, quo_q[pse_pkg::WORD_W-1]};
  assign diff   = rem_sh - {1'b0, mb_q};
  assign ge     = !diff[pse_pkg::WORD_W];
  assign rem_n  = ge ? diff[pse_pkg::WORD_W-1:0] : rem_sh[pse_pkg::WORD_W-1:0];
  assign quo_n  = {quo_q[pse_pkg::WORD_W-2:0], ge};
  assign acc_n  = ex_q[0] ? pse_pkg::word_t'(acc_q * base_q) : acc_q;

  assign div_last = (step_q == '1);
  assign pow_last = (ex_q[pse_pkg::WORD_W-1:1] == '0);

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    case (state_q)
      pse_pkg::ALU_IDLE: begin
        if (req_i.start) begin
          if (req_i.op == pse_pkg::ALU_DIV && !b_zero) begin
            state_d = pse_pkg::ALU_DIVIDE;
          end else if (req_i.op == pse_pkg::ALU_POW && !pow_trivial) begin
            state_d = pse_pkg::ALU_POWER;
          end else begin
            done_d = 1'b1;
          end
        end
      end
      pse_pkg::ALU_DIVIDE: begin
        if (div_last) begin
          state_d = pse_pkg::ALU_IDLE;
          done_d  = 1'b1;
        end
      end
      pse_pkg::ALU_POWER: begin
        if (pow_last) begin
          state_d = pse_pkg::ALU_IDLE;
          done_d  = 1'b1;
        end
      end
      default: state_d = pse_pkg::ALU_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pse_pkg::ALU_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      pse_pkg::ALU_IDLE: begin
        if (req_i.start) begin
          div0_q <= 1'b0;
          case (req_i.op)
            pse_pkg::ALU_ADD: result_q <= a_i + b_i;
            pse_pkg::ALU_SUB: result_q <= a_i - b_i;
            pse_pkg::ALU_MUL: result_q <= pse_pkg::word_t'(a_i * b_i);
            pse_pkg::ALU_DIV: begin
              result_q <= '0;
              div0_q   <= b_zero;
              quo_q    <= ma;
              rem_q    <= '0;
              mb_q     <= mb;
              neg_q    <= a_i[pse_pkg::WORD_W-1] ^ b_i[pse_pkg::WORD_W-1];
              step_q   <= '0;
            end
            pse_pkg::ALU_POW: begin
              result_q <= pse_pkg::word_t'(1);
              acc_q    <= pse_pkg::word_t'(1);
              base_q   <= a_i;
              ex_q     <= b_i;
            end
            default: result_q <= '0;
          endcase
        end
      end
      pse_pkg::ALU_DIVIDE: begin
        quo_q  <= quo_n;
        rem_q  <= rem_n;
        step_q <= step_q + STEP_W'(1);
        if (div_last) begin
          result_q <= neg_q ? (pse_pkg::word_t'(0) - quo_n) : quo_n;
        end
      end
      pse_pkg::ALU_POWER: begin
        acc_q  <= acc_n;
        base_q <= pse_pkg::word_t'(base_q * base_q);
        ex_q   <= ex_q >> 1;
        if (pow_last) begin
          result_q <= acc_n;
        end
      end
      default: ;
    endcase
  end

  assign rsp_o.done = done_q;
  assign rsp_o.div0 = div0_q;
  assign result_o   = result_q;

endmodule

[rtl/postfix_stack_evaluator_top.sv]
// ----------------------------------------------------------------------------
// postfix_stack_evaluator_top
// Evaluates reverse Polish integer expressions, one character per request.
// ----------------------------------------------------------------------------
// Usage: symbols arrive on the sym_i channel, one ASCII character per request.
// A digit pushes its value onto a 128-entry operand stack held in a
// synchronous RAM. The operators + - * / ^ pop two values and push the
// wrapped 32-bit result. Other characters are dropped. The byte 0 closes the
// expression: the top value and the sticky underflow, overflow and
// divide-by-zero flags leave as one request on res_o, and the stack and
// flags are cleared.
// Flow: a digit or ignored character is handled in the idle state. An
// operator reads its operands from the stack RAM (one read port, registered
// read data) in the RHS and LHS states, then waits for the shared arithmetic
// unit: add, subtract, multiply, a zero divisor and an exponent below one
// finish straight from the request, divide yields one quotient bit a cycle
// and power steps through the significant exponent bits. The result is
// written back when the unit answers. A terminator moves the controller to
// S_TERM, which loads the output register once the register is free.
// Reset clears the stack count, the flags and the result valid flag; the RAM
// contents are not cleared, as only entries below the count are ever read.
// If the receiver stalls, the result is held in the output register and
// further symbols are still taken; a second terminator waits in the
// controller until the held result has been taken.
// ----------------------------------------------------------------------------
module postfix_stack_evaluator_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  pse_sym_if.sink    sym_i,
  pse_res_if.source  res_o
);

  localparam logic [pse_pkg::CNT_W-1:0] CntOne  = pse_pkg::CNT_W'(1);
  localparam logic [pse_pkg::CNT_W-1:0] CntTwo  = pse_pkg::CNT_W'(2);
  localparam logic [pse_pkg::CNT_W-1:0] CntFull = pse_pkg::CNT_W'(pse_pkg::STACK_DEPTH);

  pse_pkg::ctrl_state_e state_q, state_d;
  logic [pse_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic under_q, under_d, over_q, over_d, div0_q, div0_d;
  pse_pkg::alu_op_e op_q, op_d;
  pse_pkg::word_t   rhs_q, rhs_d;

  // Output register.
  logic                 out_valid_q, out_valid_d;
  pse_pkg::word_t       out_value_q;
  logic                 out_under_q, out_over_q, out_div0_q;
  logic                 out_load;

  // Stack RAM port signals.
  logic                      mem_we, mem_re;
  logic [pse_pkg::PTR_W-1:0] mem_waddr, mem_raddr;
  pse_pkg::word_t            mem_wdata, mem_rdata;

  // Arithmetic unit.
  pse_pkg::alu_req_t alu_req;
  pse_pkg::alu_rsp_t alu_rsp;
  pse_pkg::word_t    alu_a, alu_result;

  pse_pkg::sym_dec_t         dec;
  logic                      accept;
  logic [pse_pkg::CNT_W-1:0] cnt_after_pop;
  logic                      term_empty;

  assign dec           = pse_pkg::decode_sym(sym_i.symbol);
  assign sym_i.ready   = (state_q == pse_pkg::S_IDLE);
  assign accept        = sym_i.valid && sym_i.ready;
  // Count left after popping both operands; the push that follows always fits.
  assign cnt_after_pop = (cnt_q >= CntTwo) ? (cnt_q - CntTwo) : '0;
  assign term_empty    = (cnt_q == '0);
  assign out_load      = (state_q == pse_pkg::S_TERM) && (!out_valid_q || res_o.ready);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    under_d   = under_q;
    over_d    = over_q;
    div0_d    = div0_q;
    op_d      = op_q;
    rhs_d     = rhs_q;
    mem_we    = 1'b0;
    mem_waddr = cnt_q[pse_pkg::PTR_W-1:0];
    mem_wdata = pse_pkg::word_t'(pse_pkg::SYM_W'(sym_i.symbol - pse_pkg::SYM_ZERO));
    mem_re    = 1'b0;
    mem_raddr = pse_pkg::PTR_W'(cnt_q - CntOne);
    alu_req   = '{start: 1'b0, op: op_q};
    alu_a     = '1;
    case (state_q)
      pse_pkg::S_IDLE: begin
        if (accept) begin
          if (dec.is_end) begin
            // Fetch the top value for the final pop.
            mem_re  = !term_empty;
            state_d = pse_pkg::S_TERM;
          end else if (dec.is_digit) begin
            if (cnt_q < CntFull) begin
              mem_we = 1'b1;
              cnt_d  = cnt_q + CntOne;
            end else begin
              over_d = 1'b1;
            end
          end else if (dec.is_op) begin
            op_d    = dec.op;
            mem_re  = (cnt_q >= CntOne);
            under_d = under_q || (cnt_q < CntTwo);
            state_d = pse_pkg::S_RHS;
          end
        end
      end
      pse_pkg::S_RHS: begin
        rhs_d     = (cnt_q >= CntOne) ? mem_rdata : '1;
        mem_re    = (cnt_q >= CntTwo);
        mem_raddr = pse_pkg::PTR_W'(cnt_q - CntTwo);
        state_d   = pse_pkg::S_LHS;
      end
      pse_pkg::S_LHS: begin
        alu_req.start = 1'b1;
        alu_a         = (cnt_q >= CntTwo) ? mem_rdata : '1;
        state_d       = pse_pkg::S_WAIT;
      end
      pse_pkg::S_WAIT: begin
        if (alu_rsp.done) begin
          mem_we    = 1'b1;
          mem_waddr = cnt_after_pop[pse_pkg::PTR_W-1:0];
          mem_wdata = alu_result;
          cnt_d     = cnt_after_pop + CntOne;
          div0_d    = div0_q || alu_rsp.div0;
          state_d   = pse_pkg::S_IDLE;
        end
      end
      pse_pkg::S_TERM: begin
        if (out_load) begin
          cnt_d   = '0;
          under_d = 1'b0;
          over_d  = 1'b0;
          div0_d  = 1'b0;
          state_d = pse_pkg::S_IDLE;
        end
      end
      default: state_d = pse_pkg::S_IDLE;
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && !res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pse_pkg::S_IDLE;
      cnt_q       <= '0;
      under_q     <= 1'b0;
      over_q      <= 1'b0;
      div0_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      under_q     <= under_d;
      over_q      <= over_d;
      div0_q      <= div0_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    rhs_q <= rhs_d;
    if (out_load) begin
      out_value_q <= term_empty ? '1 : mem_rdata;
      out_under_q <= under_q || term_empty;
      out_over_q  <= over_q;
      out_div0_q  <= div0_q;
    end
  end

  pse_stack_mem u_stack_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  pse_alu u_alu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (alu_req),
    .a_i      (alu_a),
    .b_i      (rhs_q),
    .rsp_o    (alu_rsp),
    .result_o (alu_result)
  );

  assign res_o.valid               = out_valid_q;
  assign res_o.value               = out_value_q;
  assign res_o.underflow_seen      = out_under_q;
  assign res_o.overflow_seen       = out_over_q;
  assign res_o.divide_by_zero_seen = out_div0_q;

  // The stack count never exceeds the depth.
  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntFull)
    else $error("stack count beyond depth");

  // The arithmetic unit only answers while the controller waits for it.
  a_alu_done_in_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_rsp.done |-> (state_q == pse_pkg::S_WAIT))
    else $error("arithmetic result arrived outside the wait state");

  // Stack writes happen only for a digit push or an operator write-back.
  a_write_states : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == pse_pkg::S_IDLE || state_q == pse_pkg::S_WAIT))
    else $error("stack write in an unexpected state");

  // Emitting a result leaves an empty stack and clear flags behind it.
  a_term_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (cnt_q == '0 && !under_q && !over_q && !div0_q && out_valid_q))
    else $error("terminator did not clear the evaluator state");

endmodule
